// ----- hdl/vbd_adaptive_init_and_velocity_update_top_macros.svh -----
// Assertion macros used by the divider RTL file of the vertex update block.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef VBD_ADAPTIVE_INIT_AND_VELOCITY_UPDATE_TOP_MACROS_SVH
`define VBD_ADAPTIVE_INIT_AND_VELOCITY_UPDATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define VBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VBD_ASSERT_IMP(lbl, ante, cons, msg)
`define VBD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/vbd_pkg.sv -----
package vbd_pkg;

  // Fixed point format of all vector values.
  localparam int FracBits = 16;

  typedef logic signed [31:0] q_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegGravX      = 3'd0,
    RegGravY      = 3'd1,
    RegGravZ      = 3'd2,
    RegStepH      = 3'd3,
    RegInvStepH   = 3'd4,
    RegInvLastH   = 3'd5,
    RegDragCoeff  = 3'd6
  } cfg_reg_e;

  // Register values after reset.
  localparam q_t          GravXReset   = 32'sd0;
  localparam q_t          GravYReset   = -32'sd642252;
  localparam q_t          GravZReset   = 32'sd0;
  localparam logic [16:0] StepHReset   = 17'd1092;
  localparam logic [31:0] InvStepReset = 32'd3932160;
  localparam logic [31:0] InvLastReset = 32'd3932160;
  localparam logic [31:0] DragReset    = 32'd0;

  // Scale factor selection for the adaptive displacement.
  typedef enum logic [1:0] {
    SclNone = 2'd0,
    SclZero = 2'd1,
    SclOne  = 2'd2,
    SclDiv  = 2'd3
  } scl_e;

  typedef struct packed {
    logic mode;
    q_t   vec_a_x;
    q_t   vec_a_y;
    q_t   vec_a_z;
    q_t   vec_b_x;
    q_t   vec_b_y;
    q_t   vec_b_z;
    q_t   ext_accel_x;
    q_t   ext_accel_y;
    q_t   ext_accel_z;
    logic has_mass;
  } vbd_in_t;

  typedef struct packed {
    q_t res_p_x;
    q_t res_p_y;
    q_t res_p_z;
    q_t res_q_x;
    q_t res_q_y;
    q_t res_q_z;
  } vbd_out_t;

  typedef struct packed {
    q_t          grav_x;
    q_t          grav_y;
    q_t          grav_z;
    logic [16:0] step_h;
    logic [31:0] inv_step_h;
    logic [31:0] inv_last_step_h;
    logic [31:0] drag_coeff;
  } vbd_cfg_t;

  // Values that ride along with an item through the divider.
  typedef struct packed {
    q_t [2:0] rp;
    q_t [2:0] rq;
    q_t [2:0] acc;
    q_t       h2;
    scl_e     scl;
  } vbd_side_t;

  localparam logic signed [66:0] SatMax = 67'sd2147483647;
  localparam logic signed [66:0] SatMin = -67'sd2147483648;
  localparam logic signed [66:0] HalfW  = 67'sd1 <<< (FracBits - 1);
  localparam logic signed [66:0] OneW   = 67'sd1 <<< FracBits;

  // Clamp a wide value to the signed 32-bit range.
  function automatic q_t sat32(input logic signed [66:0] v);
    q_t r;
    if (v > SatMax) begin
      r = 32'sh7fffffff;
    end else if (v < SatMin) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round a full product to nearest, ties upward, then saturate.
  function automatic q_t mulq(input logic signed [66:0] p);
    logic signed [66:0] r;
    r = (p + HalfW) >>> FracBits;
    return sat32(r);
  endfunction

endpackage

// ----- hdl/vbd_adaptive_init_and_velocity_update_top.sv -----
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_ready_o   | in_data_i (vbd_in_t)
// out      | output    | out_valid_o / out_ready_i | out_data_o (vbd_out_t)
// cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle while the output is not stalled; a result
// passes through the pre, divider and post stages, the one bit per stage
// divider forming the adaptive scale factor.
// Every stage carries a valid bit and loads when empty or when its content
// moves on, so stalls at the output fill bubbles and never drop or repeat.
// Reset clears all valid bits and loads the default register values.
module vbd_adaptive_init_and_velocity_update_top import vbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vbd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vbd_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  vbd_cfg_t cfg_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grav_x          <= GravXReset;
      cfg_q.grav_y          <= GravYReset;
      cfg_q.grav_z          <= GravZReset;
      cfg_q.step_h          <= StepHReset;
      cfg_q.inv_step_h      <= InvStepReset;
      cfg_q.inv_last_step_h <= InvLastReset;
      cfg_q.drag_coeff      <= DragReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGravX:     cfg_q.grav_x          <= cfg_data_i;
        RegGravY:     cfg_q.grav_y          <= cfg_data_i;
        RegGravZ:     cfg_q.grav_z          <= cfg_data_i;
        RegStepH:     cfg_q.step_h          <= cfg_data_i[16:0];
        RegInvStepH:  cfg_q.inv_step_h      <= cfg_data_i;
        RegInvLastH:  cfg_q.inv_last_step_h <= cfg_data_i;
        RegDragCoeff: cfg_q.drag_coeff      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  logic                pre_valid, pre_ready;
  vbd_side_t           pre_side;
  logic [63:0]         pre_rem, pre_ae2;
  logic                div_valid, div_ready;
  vbd_side_t           div_side;
  logic [FracBits-1:0] div_quo;

  // Products, sums and the exact dot product.
  vbd_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (pre_valid),
    .out_ready_i (pre_ready),
    .out_side_o  (pre_side),
    .out_rem_o   (pre_rem),
    .out_ae2_o   (pre_ae2)
  );

  // Scale factor quotient.
  vbd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_valid),
    .in_ready_o  (pre_ready),
    .in_side_i   (pre_side),
    .in_rem_i    (pre_rem),
    .in_ae2_i    (pre_ae2),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_side_o  (div_side),
    .out_quo_o   (div_quo)
  );

  // Adaptive displacement and output register.
  vbd_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_side_i   (div_side),
    .in_quo_i    (div_quo),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/vbd_pre.sv -----
module vbd_pre import vbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vbd_cfg_t    cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vbd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vbd_side_t   out_side_o,
  output logic [63:0] out_rem_o,
  output logic [63:0] out_ae2_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  // Stage enables: a stage loads when empty or when its content moves on.
  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // Input lanes.
  q_t va [3];
  q_t vb [3];
  q_t ex [3];
  q_t gv [3];
  assign va = '{in_data_i.vec_a_x, in_data_i.vec_a_y, in_data_i.vec_a_z};
  assign vb = '{in_data_i.vec_b_x, in_data_i.vec_b_y, in_data_i.vec_b_z};
  assign ex = '{in_data_i.ext_accel_x, in_data_i.ext_accel_y, in_data_i.ext_accel_z};
  assign gv = '{cfg_i.grav_x, cfg_i.grav_y, cfg_i.grav_z};

  // Stage 1: sums and the products with the time step.
  logic                mode1_q, mass1_q;
  q_t                  a1_q   [3];
  q_t                  dv1_q  [3];
  q_t                  sab1_q [3];
  q_t                  va1_q  [3];
  logic signed [49:0]  pvh1_q [3];
  logic [33:0]         phh1_q;
  logic [48:0]         pdh1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      mode1_q <= in_data_i.mode;
      mass1_q <= in_data_i.has_mass;
      phh1_q  <= cfg_i.step_h * cfg_i.step_h;
      pdh1_q  <= cfg_i.drag_coeff * cfg_i.step_h;
      for (int i = 0; i < 3; i++) begin
        a1_q[i]   <= sat32(67'(gv[i]) + 67'(ex[i]));
        dv1_q[i]  <= sat32(67'(va[i]) - 67'(vb[i]));
        sab1_q[i] <= sat32(67'(va[i]) + 67'(vb[i]));
        va1_q[i]  <= va[i];
        pvh1_q[i] <= va[i] * $signed({1'b0, cfg_i.step_h});
      end
    end
  end

  // Stage 2: round first products, square the acceleration, scale dv.
  logic               mode2_q, mass2_q;
  q_t                 rq02_q [3];
  q_t                 a2_q   [3];
  q_t                 sab2_q [3];
  q_t                 va2_q  [3];
  q_t                 h22_q;
  q_t                 damp2_q;
  logic signed [63:0] psq2_q  [3];
  logic signed [64:0] pacc2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mode2_q <= mode1_q;
      mass2_q <= mass1_q;
      h22_q   <= mulq(67'(phh1_q));
      damp2_q <= sat32(OneW - 67'(mulq(67'(pdh1_q))));
      for (int i = 0; i < 3; i++) begin
        rq02_q[i]  <= mulq(67'(pvh1_q[i]));
        a2_q[i]    <= a1_q[i];
        sab2_q[i]  <= sab1_q[i];
        va2_q[i]   <= va1_q[i];
        psq2_q[i]  <= a1_q[i] * a1_q[i];
        pacc2_q[i] <= dv1_q[i] * $signed({1'b0, cfg_i.inv_last_step_h});
      end
    end
  end

  // Stage 3: |a|^2, h^2*a and the damped inverse step product.
  logic               mode3_q, mass3_q;
  q_t                 rq03_q [3];
  q_t                 a3_q   [3];
  q_t                 sab3_q [3];
  q_t                 va3_q  [3];
  q_t                 acc3_q [3];
  q_t                 h23_q;
  logic [63:0]        ae23_q;
  logic signed [63:0] ph2a3_q [3];
  logic signed [64:0] pf3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      mode3_q <= mode2_q;
      mass3_q <= mass2_q;
      h23_q   <= h22_q;
      ae23_q  <= $unsigned(psq2_q[0]) + $unsigned(psq2_q[1]) + $unsigned(psq2_q[2]);
      pf3_q   <= $signed({1'b0, cfg_i.inv_step_h}) * damp2_q;
      for (int i = 0; i < 3; i++) begin
        rq03_q[i]  <= rq02_q[i];
        a3_q[i]    <= a2_q[i];
        sab3_q[i]  <= sab2_q[i];
        va3_q[i]   <= va2_q[i];
        acc3_q[i]  <= mulq(67'(pacc2_q[i]));
        ph2a3_q[i] <= h22_q * a2_q[i];
      end
    end
  end

  // Stage 4: dot product terms, inertial target and velocity factor.
  logic               mode4_q, mass4_q;
  q_t                 rq04_q [3];
  q_t                 rps4_q [3];
  q_t                 a4_q   [3];
  q_t                 sab4_q [3];
  q_t                 va4_q  [3];
  q_t                 h24_q;
  logic [63:0]        ae24_q;
  logic signed [63:0] pp4_q [3];
  logic signed [32:0] fac4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      mode4_q <= mode3_q;
      mass4_q <= mass3_q;
      h24_q   <= h23_q;
      ae24_q  <= ae23_q;
      fac4_q  <= mass3_q ? 33'(mulq(67'(pf3_q))) : $signed({1'b0, cfg_i.inv_step_h});
      for (int i = 0; i < 3; i++) begin
        rq04_q[i] <= rq03_q[i];
        rps4_q[i] <= mass3_q ? sat32(67'(rq03_q[i]) + 67'(mulq(67'(ph2a3_q[i]))))
                             : rq03_q[i];
        a4_q[i]   <= a3_q[i];
        sab4_q[i] <= sab3_q[i];
        va4_q[i]  <= va3_q[i];
        pp4_q[i]  <= acc3_q[i] * a3_q[i];
      end
    end
  end

  // Stage 5: exact dot product and the end mode velocity products.
  logic               mode5_q, mass5_q;
  q_t                 rq05_q [3];
  q_t                 rps5_q [3];
  q_t                 a5_q   [3];
  q_t                 sab5_q [3];
  q_t                 h25_q;
  logic [63:0]        ae25_q;
  logic signed [65:0] dsum5_q;
  logic signed [64:0] pvf5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      mode5_q <= mode4_q;
      mass5_q <= mass4_q;
      h25_q   <= h24_q;
      ae25_q  <= ae24_q;
      dsum5_q <= 66'(pp4_q[0]) + 66'(pp4_q[1]) + 66'(pp4_q[2]);
      for (int i = 0; i < 3; i++) begin
        rq05_q[i] <= rq04_q[i];
        rps5_q[i] <= rps4_q[i];
        a5_q[i]   <= a4_q[i];
        sab5_q[i] <= sab4_q[i];
        pvf5_q[i] <= va4_q[i] * fac4_q;
      end
    end
  end

  // Classify the scale factor and pick the results known so far.
  always_comb begin
    out_side_o.h2 = h25_q;
    for (int i = 0; i < 3; i++) begin
      out_side_o.rp[i]  = mode5_q ? mulq(67'(pvf5_q[i])) : rps5_q[i];
      out_side_o.rq[i]  = mode5_q ? sab5_q[i] : rq05_q[i];
      out_side_o.acc[i] = a5_q[i];
    end
    if (mode5_q || !mass5_q || ae25_q == 64'd0) begin
      out_side_o.scl = SclNone;
    end else if (dsum5_q <= 66'sd0) begin
      out_side_o.scl = SclZero;
    end else if (dsum5_q >= $signed({2'b00, ae25_q})) begin
      out_side_o.scl = SclOne;
    end else begin
      out_side_o.scl = SclDiv;
    end
  end

  assign out_valid_o = v5_q;
  assign out_rem_o   = dsum5_q[63:0];
  assign out_ae2_o   = ae25_q;

endmodule

// ----- hdl/vbd_div.sv -----
`include "vbd_adaptive_init_and_velocity_update_top_macros.svh"
module vbd_div import vbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vbd_side_t           in_side_i,
  input  logic [63:0]         in_rem_i,
  input  logic [63:0]         in_ae2_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vbd_side_t           out_side_o,
  output logic [FracBits-1:0] out_quo_o
);

  localparam int Last = FracBits - 1;

  logic [Last:0]         v_q;
  logic [Last:0]         en;
  logic [63:0]           rem_q  [FracBits];
  logic [63:0]           ae2_q  [FracBits];
  logic [FracBits-1:0]   q_q    [FracBits];
  vbd_side_t             side_q [FracBits];

  // One quotient bit per stage: restoring division of rem by ae2.
  for (genvar k = 0; k < FracBits; k++) begin : g_stage
    logic                v_in;
    logic [63:0]         rem_in;
    logic [63:0]         ae2_in;
    logic [FracBits-1:0] q_in;
    vbd_side_t           side_in;
    logic [64:0]         two;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = in_rem_i;
      assign ae2_in  = in_ae2_i;
      assign q_in    = '0;
      assign side_in = in_side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign ae2_in  = ae2_q[k-1];
      assign q_in    = q_q[k-1];
      assign side_in = side_q[k-1];
    end

    if (k == Last) begin : g_tail
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_body
      assign en[k] = !v_q[k] || en[k+1];
    end

    assign two = {rem_in, 1'b0};
    assign ge  = two >= {1'b0, ae2_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && v_in) begin
        rem_q[k]  <= ge ? 64'(two - {1'b0, ae2_in}) : two[63:0];
        ae2_q[k]  <= ae2_in;
        q_q[k]    <= {q_in[FracBits-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[Last];
  assign out_side_o  = side_q[Last];
  assign out_quo_o   = q_q[Last];

  // The remainder stays below the divisor for a real division.
  `VBD_ASSERT_IMP(a_rem_bound, v_q[Last] && side_q[Last].scl == SclDiv, rem_q[Last] < ae2_q[Last], "divider remainder out of range")
  // A beat taken in lands in the first stage.
  `VBD_ASSERT_NXT(a_enter, in_valid_i && en[0], v_q[0], "divider lost an entering beat")
  // A blocked last stage keeps its quotient.
  `VBD_ASSERT_NXT(a_hold, v_q[Last] && !out_ready_i, v_q[Last] && $stable(q_q[Last]), "divider dropped a stalled quotient")

endmodule

// ----- hdl/vbd_post.sv -----
module vbd_post import vbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vbd_side_t           in_side_i,
  input  logic [FracBits-1:0] in_quo_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vbd_out_t            out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // Stage 1: select s and form h^2*s.
  q_t                 s_sel;
  vbd_side_t          side1_q;
  logic signed [63:0] pc1_q;

  always_comb begin
    case (in_side_i.scl)
      SclOne:  s_sel = q_t'(OneW[31:0]);
      SclDiv:  s_sel = q_t'(32'(in_quo_i));
      default: s_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      side1_q <= in_side_i;
      pc1_q   <= $signed(in_side_i.h2) * s_sel;
    end
  end

  // Stage 2: round c and scale each acceleration lane.
  vbd_side_t          side2_q;
  logic signed [63:0] pca2_q [3];
  q_t                 c_now;

  assign c_now = mulq(67'(pc1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      side2_q <= side1_q;
      for (int i = 0; i < 3; i++) begin
        pca2_q[i] <= c_now * $signed(side1_q.acc[i]);
      end
    end
  end

  // Stage 3: output register with the adjusted displacement.
  q_t rq_fin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side2_q.scl == SclNone) begin
        rq_fin[i] = side2_q.rq[i];
      end else begin
        rq_fin[i] = sat32(67'($signed(side2_q.rq[i])) + 67'(mulq(67'(pca2_q[i]))));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out_data_o.res_p_x <= side2_q.rp[0];
      out_data_o.res_p_y <= side2_q.rp[1];
      out_data_o.res_p_z <= side2_q.rp[2];
      out_data_o.res_q_x <= rq_fin[0];
      out_data_o.res_q_y <= rq_fin[1];
      out_data_o.res_q_z <= rq_fin[2];
    end
  end

  assign out_valid_o = v3_q;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import vbd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  vbd_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  vbd_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;

  vbd_adaptive_init_and_velocity_update_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Mirror of the block's registers.
  longint grav[3];
  longint step_h, inv_step_h, inv_last_h, drag;

  vbd_in_t  pending_vertices[$];
  vbd_out_t expected_updates[$];
  int  mismatches = 0;
  int  start_beats = 0;
  int  end_beats = 0;
  int  results_seen = 0;
  bit  in_fire = 0;
  bit  out_fire = 0;
  bit  no_idle = 0;
  int  send_gap = 0;
  int  recv_wait = 0;
  int  hold_left = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Clamp to the signed 32-bit range.
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed point product, rounded to nearest with ties upward, saturated.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FracBits - 1));
    return clamp32(p >>> FracBits);
  endfunction

  // Expected vertex update for one input beat under the current registers.
  function automatic vbd_out_t vertex_update(vbd_in_t it);
    longint va[3], vb[3], ex[3], a[3], rp[3], rq[3];
    longint h, h2, acc, prod, s, c, damp, factor;
    longint unsigned ae2, pos, neg, d, rem, q;
    vbd_out_t r;
    va[0] = it.vec_a_x; va[1] = it.vec_a_y; va[2] = it.vec_a_z;
    vb[0] = it.vec_b_x; vb[1] = it.vec_b_y; vb[2] = it.vec_b_z;
    ex[0] = it.ext_accel_x; ex[1] = it.ext_accel_y; ex[2] = it.ext_accel_z;
    h = step_h;
    if (!it.mode) begin
      for (int i = 0; i < 3; i++) begin
        rq[i] = fx_mul(va[i], h);
        rp[i] = rq[i];
      end
      if (it.has_mass) begin
        h2 = fx_mul(h, h);
        ae2 = 0; pos = 0; neg = 0;
        for (int i = 0; i < 3; i++) begin
          a[i] = clamp32(grav[i] + ex[i]);
          rp[i] = clamp32(rp[i] + fx_mul(h2, a[i]));
          ae2 += longint'(a[i] * a[i]);
          acc = fx_mul(clamp32(va[i] - vb[i]), inv_last_h);
          prod = acc * a[i];
          if (prod >= 0) pos += prod;
          else neg += -prod;
        end
        // Zero total acceleration leaves the displacement at v*h.
        if (ae2 != 0) begin
          s = 0;
          if (pos > neg) begin
            d = pos - neg;
            if (d >= ae2) begin
              s = 64'sd1 <<< FracBits;
            end else begin
              rem = d;
              q = 0;
              for (int k = 0; k < FracBits; k++) begin
                q = q << 1;
                if (rem >= ae2 - rem) begin
                  q = q | 1;
                  rem = rem - (ae2 - rem);
                end else begin
                  rem = rem << 1;
                end
              end
              s = q;
            end
          end
          c = fx_mul(h2, s);
          for (int i = 0; i < 3; i++) rq[i] = clamp32(rq[i] + fx_mul(c, a[i]));
        end
      end
    end else begin
      factor = inv_step_h;
      if (it.has_mass) begin
        damp = clamp32((64'sd1 <<< FracBits) - fx_mul(drag, h));
        factor = fx_mul(inv_step_h, damp);
      end
      for (int i = 0; i < 3; i++) begin
        rp[i] = fx_mul(va[i], factor);
        rq[i] = clamp32(vb[i] + va[i]);
      end
    end
    r.res_p_x = rp[0][31:0]; r.res_p_y = rp[1][31:0]; r.res_p_z = rp[2][31:0];
    r.res_q_x = rq[0][31:0]; r.res_q_y = rq[1][31:0]; r.res_q_z = rq[2][31:0];
    return r;
  endfunction

  // Sender: offers the next pending vertex after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_fire) begin
        // Beat still waiting for acceptance.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        in_data <= pending_vertices.pop_front();
        in_valid <= 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per result, plus an optional long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_fire) begin
        recv_wait = no_idle ? 0 : $urandom_range(0, 7);
        out_ready <= (recv_wait == 0);
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= (recv_wait == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each input beat, checks each output beat.
  always @(posedge clk_i) begin
    vbd_out_t exp_r;
    in_fire  <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    if (rst_ni && in_valid && in_ready) begin
      expected_updates.push_back(vertex_update(in_data));
      if (in_data.mode) end_beats++;
      else start_beats++;
    end
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", out_data);
      end else begin
        exp_r = expected_updates.pop_front();
        if (exp_r.res_p_x !== out_data.res_p_x || exp_r.res_p_y !== out_data.res_p_y ||
            exp_r.res_p_z !== out_data.res_p_z || exp_r.res_q_x !== out_data.res_q_x ||
            exp_r.res_q_y !== out_data.res_q_y || exp_r.res_q_z !== out_data.res_q_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %p", exp_r);
            $display("          actual   %p", out_data);
          end
        end
      end
    end
  end

  // Write all seven registers and update the mirror.
  task automatic write_regs(longint gx, longint gy, longint gz, longint h,
                            longint inv, longint inv_last, longint dr);
    logic [31:0] vals[7];
    vals[RegGravX] = gx[31:0]; vals[RegGravY] = gy[31:0]; vals[RegGravZ] = gz[31:0];
    vals[RegStepH] = h[31:0]; vals[RegInvStepH] = inv[31:0];
    vals[RegInvLastH] = inv_last[31:0]; vals[RegDragCoeff] = dr[31:0];
    for (int i = 0; i < 7; i++) begin
      @(negedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= 3'(i);
      cfg_data <= vals[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    grav[0] = $signed(vals[RegGravX]);
    grav[1] = $signed(vals[RegGravY]);
    grav[2] = $signed(vals[RegGravZ]);
    step_h = vals[RegStepH][16:0];
    inv_step_h = vals[RegInvStepH];
    inv_last_h = vals[RegInvLastH];
    drag = vals[RegDragCoeff];
  endtask

  // Wait until every offered vertex has produced its result.
  task automatic drain();
    while (pending_vertices.size() > 0 || in_valid || expected_updates.size() > 0)
      @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh80000000;
          1: return 32'sh7fffffff;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return q_t'($urandom());
      default: return q_t'(int'($urandom_range(0, 32'h200000)) - 32'h100000);
    endcase
  endfunction

  function automatic q_t near(q_t v);
    return q_t'(longint'(v) + longint'(int'($urandom_range(0, 8192)) - 4096));
  endfunction

  function automatic vbd_in_t rand_vertex();
    vbd_in_t it;
    it.mode = $urandom_range(0, 1);
    it.has_mass = ($urandom_range(0, 4) != 0);
    it.vec_a_x = rand_q(); it.vec_a_y = rand_q(); it.vec_a_z = rand_q();
    // Mostly keep last velocity near velocity so the scale lands in range.
    if (!it.mode && $urandom_range(0, 2) != 0) begin
      it.vec_b_x = near(it.vec_a_x); it.vec_b_y = near(it.vec_a_y);
      it.vec_b_z = near(it.vec_a_z);
    end else begin
      it.vec_b_x = rand_q(); it.vec_b_y = rand_q(); it.vec_b_z = rand_q();
    end
    it.ext_accel_x = rand_q(); it.ext_accel_y = rand_q(); it.ext_accel_z = rand_q();
    return it;
  endfunction

  function automatic vbd_in_t mk(bit m, bit ms, q_t ax, q_t ay, q_t az,
                                 q_t bx, q_t by, q_t bz, q_t ex, q_t ey, q_t ez);
    vbd_in_t it;
    it = '{m, ax, ay, az, bx, by, bz, ex, ey, ez, ms};
    return it;
  endfunction

  task automatic push_random(int n);
    repeat (n) pending_vertices.push_back(rand_vertex());
  endtask

  localparam q_t QMax = 32'sh7fffffff;
  localparam q_t QMin = 32'sh80000000;
  localparam q_t QOne = 32'sh00010000;

  // Stimulus sequence, phase by phase.
  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegGravX;
    cfg_data = '0;
    grav[0] = GravXReset; grav[1] = GravYReset; grav[2] = GravZReset;
    step_h = StepHReset; inv_step_h = InvStepReset;
    inv_last_h = InvLastReset; drag = DragReset;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: directed corners first.
    pending_vertices.push_back(mk(0, 1, QOne, 0, 0, 0, 0, 0, 0, 32'sd642252, 0));
    pending_vertices.push_back(mk(0, 1, QOne, QOne, 0, QOne, QOne, 0, 0, 0, 0));
    pending_vertices.push_back(mk(0, 1, 0, -32'sd10000, 0, 0, 0, 0, 0, 0, 0));
    pending_vertices.push_back(mk(0, 1, 0, -32'sd1000, 0, 0, 0, 0, 0, 0, 0));
    pending_vertices.push_back(mk(0, 1, 0, 32'sd5000, 0, 0, 0, 0, 0, 0, 0));
    pending_vertices.push_back(mk(0, 0, QMax, QMin, 0, QMin, QMax, -1, QMax, QMax, QMax));
    pending_vertices.push_back(mk(0, 1, QMax, QMin, -1, QMin, QMax, 0, QMax, QMin, QMax));
    pending_vertices.push_back(mk(0, 1, QMin, QMax, QMax, QMax, QMin, QMin, QMin, QMin, QMin));
    pending_vertices.push_back(mk(1, 0, QOne, -QOne, 0, QMax, QMin, 5, QMax, 0, 0));
    pending_vertices.push_back(mk(1, 1, QMax, QMin, -1, QMax, QMin, 0, 0, 0, 0));
    pending_vertices.push_back(mk(1, 1, QMin, QMax, 1, QMin, QMax, -1, 0, 0, 0));
    pending_vertices.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, -1, -1, -1));
    push_random(200);
    drain();

    // Random registers, no idling on either side.
    no_idle = 1;
    write_regs(int'($urandom()), int'($urandom()), int'($urandom()),
               $urandom_range(0, 65536), $urandom(), $urandom(), $urandom());
    push_random(200);
    drain();
    no_idle = 0;

    // Extreme values, with a long receiver hold-off to fill the pipeline.
    write_regs(2147483647, -2147483648, 2147483647, 65536,
               64'hffffffff, 64'hffffffff, 64'hffffffff);
    hold_left = 300;
    push_random(200);
    drain();

    // Zero step, zero inverses and no gravity.
    write_regs(0, 0, 0, 0, 0, 0, 0);
    pending_vertices.push_back(mk(0, 1, QOne, QOne, QOne, 0, 0, 0, 0, 0, 0));
    push_random(200);
    drain();

    // Realistic small steps with drag large enough to flip the damping sign.
    write_regs(0, -642252, 0, 1092, 3932160, 3932160, 64'd4000000);
    hold_left = 100;
    push_random(230);
    drain();

    // Random registers with the smallest gravity and a random nonzero step.
    write_regs(-2147483648, 0, 1, $urandom_range(1, 65536), $urandom(), $urandom(),
               $urandom_range(0, 1 << 20));
    push_random(230);
    drain();

    $display("Covered %0d start beats and %0d end beats over six register settings,",
             start_beats, end_beats);
    $display("including register extremes, output hold-off and back-to-back streams.");
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
